// ----- hw/rtl/calp_pkg.sv -----
// Shared types, character codes and line kinds for the calculator line parser.
`timescale 1ns / 1ps

package calp_pkg;

    // Fixed field widths
    localparam int ACC_W = 54;
    localparam int CNT_W = 5;
    localparam int DIGIT_LIMIT_DEFAULT = 16;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_UP_C  = 8'h43;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_LO_R  = 8'h72;

    // Input actions
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EOL  = 1'b1;

    // Line kinds
    typedef enum logic [3:0] {
        KIND_NUMBER   = 4'd0,
        KIND_ADD      = 4'd1,
        KIND_SUB      = 4'd2,
        KIND_MUL      = 4'd3,
        KIND_DIV      = 4'd4,
        KIND_MEM_ADD  = 4'd5,
        KIND_MEM_SUB  = 4'd6,
        KIND_MEM_CLR  = 4'd7,
        KIND_MEM_READ = 4'd8,
        KIND_EXIT     = 4'd9,
        KIND_SYNTAX   = 4'd10,
        KIND_OVERFLOW = 4'd11
    } t_kind;

    // Input item
    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } t_in;

    // Result item
    typedef struct packed {
        t_kind              line_kind;
        logic               first_present;
        logic               first_negative;
        logic [ACC_W-1:0]   first_digits;
        logic [CNT_W-1:0]   first_fraction_count;
        logic               first_overflow;
        logic               second_present;
        logic               second_negative;
        logic [ACC_W-1:0]   second_digits;
        logic [CNT_W-1:0]   second_fraction_count;
        logic               second_overflow;
    } t_out;

    // State of one operand
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] frac;
        logic             started;
        logic             ended;
        logic             negative;
        logic             decimal;
    } t_operand;

    // Commands from the line control to one operand
    typedef struct packed {
        logic take;
        logic close;
        logic clear;
    } t_op_cmd;

endpackage

// ----- hw/rtl/calculator_line_parser.sv -----
// Top level of the calculator line parser: line control and result register.
//
// Usage: feed one line of calculator text a character per transfer on the
// input channel (action = character, ch = ASCII code), then one transfer with
// action = end of line. Character transfers produce no result. The end-of-line
// transfer produces one result item on the output channel: the line kind and
// both operands (present, sign, digits, fraction count, overflow).
// Throughput: one input transfer per cycle unless the input stalls. Each
// character updates the line and operand registers in the cycle it is taken.
// Latency: the result is valid in the cycle after the end-of-line transfer.
// The result register holds one item; input keeps flowing while it is being
// taken. While the result is valid and the receiver stalls, the input side
// stalls as well, and the stalled result holds its value.
// Reset (synchronous, active low) clears the line state and drops any
// pending result. After each end of line all line state returns to reset.
`timescale 1ns / 1ps

module calculator_line_parser
    import calp_pkg::*;
#(
    parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DIGIT_LIMIT);

    t_kind r_kind;
    t_kind n_kind;
    logic  r_err;
    logic  n_err;
    logic  r_await;
    logic  n_await;
    logic  r_out_valid;
    logic  n_out_valid;
    t_out  r_out;
    t_out  n_out;

    t_operand op0;
    t_operand op1;
    t_op_cmd  cmd0;
    t_op_cmd  cmd1;
    logic     acc0;
    logic     acc1;

    logic  in_xfer;
    logic  char_go;
    logic  eol_go;
    logic  end0;
    logic  ended0;
    logic  take1;
    logic  do_switch;
    logic  ov0;
    logic  ov1;
    t_kind cls;

    calp_operand #(
        .DIGIT_LIMIT(DIGIT_LIMIT)
    ) u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ch     (i_in_data.ch),
        .i_cmd    (cmd0),
        .o_accepts(acc0),
        .o_state  (op0)
    );

    calp_operand #(
        .DIGIT_LIMIT(DIGIT_LIMIT)
    ) u_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ch     (i_in_data.ch),
        .i_cmd    (cmd1),
        .o_accepts(acc1),
        .o_state  (op1)
    );

    // Stall input only while a result waits and the receiver stalls
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & !o_in_stall;
    assign char_go    = in_xfer & (i_in_data.action == ACT_CHAR) & !r_err & !r_await;
    assign eol_go     = in_xfer & (i_in_data.action == ACT_EOL);

    // Offer the character to the first operand, then the second
    always_comb begin
        end0      = char_go & !acc0;
        ended0    = op0.ended | op0.started;
        take1     = end0 & ended0 & acc1;
        do_switch = end0 & !take1;
        cmd0.take  = char_go & acc0;
        cmd0.close = end0;
        cmd0.clear = eol_go;
        cmd1.take  = take1;
        cmd1.close = 1'b0;
        cmd1.clear = eol_go;
    end

    // Line control: memory suffix, operators, exit mark, error latch
    always_comb begin
        n_kind  = r_kind;
        n_err   = r_err;
        n_await = r_await;
        if (eol_go) begin
            n_kind  = KIND_NUMBER;
            n_err   = 1'b0;
            n_await = 1'b0;
        end else if (in_xfer && i_in_data.action == ACT_CHAR && !r_err && r_await) begin
            n_await = 1'b0;
            case (i_in_data.ch)
                CH_PLUS:           n_kind = KIND_MEM_ADD;
                CH_MINUS:          n_kind = KIND_MEM_SUB;
                CH_UP_C, CH_LO_C:  n_kind = KIND_MEM_CLR;
                CH_UP_R, CH_LO_R:  n_kind = KIND_MEM_READ;
                default:           n_err  = 1'b1;
            endcase
        end else if (do_switch) begin
            case (i_in_data.ch)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                    if (r_kind != KIND_NUMBER || !ended0) begin
                        n_err = 1'b1;
                    end else if (i_in_data.ch == CH_PLUS) begin
                        n_kind = KIND_ADD;
                    end else if (i_in_data.ch == CH_MINUS) begin
                        n_kind = KIND_SUB;
                    end else if (i_in_data.ch == CH_STAR) begin
                        n_kind = KIND_MUL;
                    end else begin
                        n_kind = KIND_DIV;
                    end
                end
                CH_SPACE, CH_TAB: begin
                end
                CH_HASH: begin
                    if (r_kind != KIND_NUMBER) begin
                        n_err = 1'b1;
                    end else begin
                        n_kind = KIND_EXIT;
                    end
                end
                CH_UP_M, CH_LO_M: begin
                    if (r_kind != KIND_NUMBER) begin
                        n_err = 1'b1;
                    end else begin
                        n_await = 1'b1;
                    end
                end
                default: n_err = 1'b1;
            endcase
        end
    end

    // Classify the finished line; an operand counts once it has started
    always_comb begin
        ov0 = op0.total > LIMIT;
        ov1 = op1.total > LIMIT;
        if (r_err || r_await) begin
            cls = KIND_SYNTAX;
        end else if (r_kind inside {[KIND_ADD:KIND_DIV]}) begin
            if (!op0.started || !op1.started) begin
                cls = KIND_SYNTAX;
            end else if (ov0 || ov1) begin
                cls = KIND_OVERFLOW;
            end else begin
                cls = r_kind;
            end
        end else if (r_kind inside {[KIND_MEM_ADD:KIND_EXIT]}) begin
            cls = (op0.started || op1.started) ? KIND_SYNTAX : r_kind;
        end else if (op0.started && ov0) begin
            cls = KIND_OVERFLOW;
        end else begin
            cls = KIND_NUMBER;
        end
    end

    // Build the result item and advance the output register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        if (eol_go) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.line_kind = cls;
            if (cls != KIND_SYNTAX) begin
                n_out.first_present         = op0.started;
                n_out.first_negative        = op0.negative;
                n_out.first_digits          = ov0 ? '0 : op0.acc;
                n_out.first_fraction_count  = ov0 ? '0 : op0.frac;
                n_out.first_overflow        = ov0;
                n_out.second_present        = op1.started;
                n_out.second_negative       = op1.negative;
                n_out.second_digits         = ov1 ? '0 : op1.acc;
                n_out.second_fraction_count = ov1 ? '0 : op1.frac;
                n_out.second_overflow       = ov1;
            end
        end
    end

    // Hold line control state and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_NUMBER;
            r_err       <= 1'b0;
            r_await     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_kind      <= n_kind;
            r_err       <= n_err;
            r_await     <= n_await;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/calp_operand.sv -----
// One decimal operand: digit accumulator, digit counts and sign/point flags.
`timescale 1ns / 1ps

module calp_operand
    import calp_pkg::*;
#(
    parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_ch,
    input  t_op_cmd    i_cmd,
    output logic       o_accepts,
    output t_operand   o_state
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DIGIT_LIMIT);

    t_operand r_op;
    t_operand n_op;

    logic       is_digit;
    logic [3:0] digit_val;

    // Classify the character against the current operand state
    always_comb begin
        is_digit  = (i_ch inside {[CH_ZERO:CH_NINE]});
        digit_val = 4'(i_ch - CH_ZERO);
        o_accepts = (i_ch == CH_SPACE) ||
                    (!r_op.ended && (is_digit ||
                                     (i_ch == CH_DOT && !r_op.decimal) ||
                                     (i_ch == CH_MINUS && !r_op.started)));
    end

    // Apply take, close or clear
    always_comb begin
        n_op = r_op;
        if (i_cmd.clear) begin
            n_op = '0;
        end else if (i_cmd.take) begin
            if (i_ch == CH_SPACE) begin
                n_op.ended = r_op.ended | r_op.started;
            end else if (is_digit) begin
                if (r_op.total < LIMIT) begin
                    n_op.acc = ACC_W'((r_op.acc << 3) + (r_op.acc << 1) + ACC_W'(digit_val));
                end
                if (r_op.total <= LIMIT) begin
                    n_op.total = r_op.total + 1'b1;
                    if (r_op.decimal) begin
                        n_op.frac = r_op.frac + 1'b1;
                    end
                end
                n_op.started = 1'b1;
            end else if (i_ch == CH_DOT) begin
                n_op.decimal = 1'b1;
                n_op.started = 1'b1;
            end else begin
                n_op.negative = !r_op.negative;
            end
        end else if (i_cmd.close) begin
            n_op.ended = r_op.ended | r_op.started;
        end
    end

    // Hold operand state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= n_op;
        end
    end

    assign o_state = r_op;

endmodule

// ----- test/tb_calculator_line_parser.sv -----
// Self-checking testbench for the calculator line parser.
`timescale 1ns / 1ps

module tb_calculator_line_parser;
    import calp_pkg::*;

    localparam int DIGIT_LIMIT = DIGIT_LIMIT_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // Digits, count and flags that one operand contributes to a result
    typedef struct packed {
        logic             present;
        logic             negative;
        logic [ACC_W-1:0] digits;
        logic [CNT_W-1:0] frac_count;
        logic             overflow;
    } t_operand_report;

    // Line parse predictor and queue of expected end-of-line results
    class line_scoreboard;
        t_kind    kind_so_far;
        bit       error_latched;
        bit       await_suffix;
        t_operand opnd[2];
        t_out     expected_lines[$];
        int       errors;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            kind_so_far   = KIND_NUMBER;
            error_latched = 1'b0;
            await_suffix  = 1'b0;
            opnd[0]       = '0;
            opnd[1]       = '0;
        endfunction

        // Close an operand once it has started; report whether it is closed
        function bit close_operand(int i);
            if (opnd[i].started)
                opnd[i].ended = 1'b1;
            return opnd[i].ended;
        endfunction

        // Offer one character to an operand; report whether it was taken
        function bit take_char(int i, logic [7:0] c);
            if (c == CH_SPACE) begin
                void'(close_operand(i));
                return 1'b1;
            end
            if (opnd[i].ended)
                return 1'b0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (opnd[i].total < DIGIT_LIMIT)
                    opnd[i].acc = opnd[i].acc * 10 + ACC_W'(c - CH_ZERO);
                if (opnd[i].total <= DIGIT_LIMIT) begin
                    opnd[i].total++;
                    if (opnd[i].decimal)
                        opnd[i].frac++;
                end
                opnd[i].started = 1'b1;
                return 1'b1;
            end
            if (c == CH_DOT && !opnd[i].decimal) begin
                opnd[i].decimal = 1'b1;
                opnd[i].started = 1'b1;
                return 1'b1;
            end
            if (c == CH_MINUS && !opnd[i].started) begin
                opnd[i].negative = !opnd[i].negative;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit over_limit(int i);
            return opnd[i].total > DIGIT_LIMIT;
        endfunction

        function void parse_char(logic [7:0] c);
            if (error_latched)
                return;
            // The character after M is always used up as the memory suffix
            if (await_suffix) begin
                await_suffix = 1'b0;
                case (c)
                    CH_PLUS:          kind_so_far = KIND_MEM_ADD;
                    CH_MINUS:         kind_so_far = KIND_MEM_SUB;
                    CH_UP_C, CH_LO_C: kind_so_far = KIND_MEM_CLR;
                    CH_UP_R, CH_LO_R: kind_so_far = KIND_MEM_READ;
                    default:          error_latched = 1'b1;
                endcase
                return;
            end
            if (take_char(0, c))
                return;
            if (close_operand(0) && take_char(1, c))
                return;
            // Refused by both operands: operator, separator or command
            case (c)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                    if (kind_so_far != KIND_NUMBER || !close_operand(0))
                        error_latched = 1'b1;
                    else
                        kind_so_far = (c == CH_PLUS)  ? KIND_ADD :
                                      (c == CH_MINUS) ? KIND_SUB :
                                      (c == CH_STAR)  ? KIND_MUL : KIND_DIV;
                end
                CH_SPACE, CH_TAB: ;
                CH_HASH: begin
                    if (kind_so_far != KIND_NUMBER)
                        error_latched = 1'b1;
                    else
                        kind_so_far = KIND_EXIT;
                end
                CH_UP_M, CH_LO_M: begin
                    if (kind_so_far != KIND_NUMBER)
                        error_latched = 1'b1;
                    else
                        await_suffix = 1'b1;
                end
                default: error_latched = 1'b1;
            endcase
        endfunction

        function t_kind classify_line();
            bit f1, f2;
            if (error_latched || await_suffix)
                return KIND_SYNTAX;
            void'(close_operand(0));
            void'(close_operand(1));
            f1 = opnd[0].started && opnd[0].ended;
            f2 = opnd[1].started && opnd[1].ended;
            if (kind_so_far >= KIND_ADD && kind_so_far <= KIND_DIV) begin
                if (!f1 || !f2)
                    return KIND_SYNTAX;
                if (over_limit(0) || over_limit(1))
                    return KIND_OVERFLOW;
                return kind_so_far;
            end
            if (kind_so_far >= KIND_MEM_ADD && kind_so_far <= KIND_EXIT)
                return (f1 || f2) ? KIND_SYNTAX : kind_so_far;
            if (f1 && over_limit(0))
                return KIND_OVERFLOW;
            return KIND_NUMBER;
        endfunction

        // Overflowed operands report no digits and no fraction count
        function t_operand_report report_operand(int i);
            t_operand_report r;
            r.present    = opnd[i].started && opnd[i].ended;
            r.negative   = opnd[i].negative;
            r.overflow   = over_limit(i);
            r.digits     = r.overflow ? '0 : opnd[i].acc;
            r.frac_count = r.overflow ? '0 : opnd[i].frac;
            return r;
        endfunction

        // Advance the predictor by one accepted input transfer
        function void note_input(t_in it);
            t_out            want;
            t_operand_report r0, r1;
            if (it.action == ACT_CHAR) begin
                parse_char(it.ch);
                return;
            end
            want = '0;
            want.line_kind = classify_line();
            if (want.line_kind != KIND_SYNTAX) begin
                r0 = report_operand(0);
                r1 = report_operand(1);
                want.first_present         = r0.present;
                want.first_negative        = r0.negative;
                want.first_digits          = r0.digits;
                want.first_fraction_count  = r0.frac_count;
                want.first_overflow        = r0.overflow;
                want.second_present        = r1.present;
                want.second_negative       = r1.negative;
                want.second_digits         = r1.digits;
                want.second_fraction_count = r1.frac_count;
                want.second_overflow       = r1.overflow;
            end
            expected_lines.push_back(want);
            clear_line();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(t_out got);
            t_out want;
            if (expected_lines.size() == 0) begin
                $error("result with no line pending: line_kind %0d", got.line_kind);
                errors++;
                return;
            end
            want = expected_lines.pop_front();
            compare_field("line_kind", want.line_kind, got.line_kind);
            compare_field("first_present", want.first_present, got.first_present);
            compare_field("first_negative", want.first_negative, got.first_negative);
            compare_field("first_digits", want.first_digits, got.first_digits);
            compare_field("first_fraction_count", want.first_fraction_count,
                          got.first_fraction_count);
            compare_field("first_overflow", want.first_overflow, got.first_overflow);
            compare_field("second_present", want.second_present, got.second_present);
            compare_field("second_negative", want.second_negative, got.second_negative);
            compare_field("second_digits", want.second_digits, got.second_digits);
            compare_field("second_fraction_count", want.second_fraction_count,
                          got.second_fraction_count);
            compare_field("second_overflow", want.second_overflow, got.second_overflow);
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    line_scoreboard sb = new();

    int         idle_cycles   = 0;
    int         items_sent    = 0;
    int         send_idle_pct = 15;
    int         recv_idle_pct = 78;
    int         hold_request  = 0;
    int         hold_left     = 0;
    logic [7:0] text[$];

    calculator_line_parser #(
        .DIGIT_LIMIT(DIGIT_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Observe transfers on both channels; count cycles without progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_in_data);
            idle_cycles <= ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) ?
                           0 : idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb_calculator_line_parser: done, errors");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when one is requested
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Offer one item, with a random gap ahead of it, and hold it until taken
    task send_item(t_in it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Send the buffered characters, then end of line with a junk code
    task send_line();
        t_in it;
        foreach (text[i]) begin
            it.action = ACT_CHAR;
            it.ch     = text[i];
            send_item(it);
        end
        it.action = ACT_EOL;
        it.ch     = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task load_text(string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    function logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0: return 8'($urandom_range(0, 255));
            1: return CH_ZERO + 8'($urandom_range(0, 9));
            2: return CH_DOT;
            3: return CH_MINUS;
            4: return ($urandom_range(0, 1) != 0) ? CH_STAR : CH_SLASH;
            5: return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
            6: return ($urandom_range(0, 1) != 0) ? CH_HASH : CH_UP_M;
            default: return ($urandom_range(0, 1) != 0) ? CH_LO_C : CH_UP_R;
        endcase
    endfunction

    task put_gap();
        case ($urandom_range(0, 5))
            0: text.push_back(CH_SPACE);
            1: text.push_back(CH_TAB);
            2: begin
                text.push_back(CH_SPACE);
                text.push_back(CH_SPACE);
            end
            default: ;
        endcase
    endtask

    // Leading minus signs, digits (now and then past the limit), optional point
    task put_number();
        int n_minus, n_dig, dot_at;
        n_minus = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        n_dig   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 5);
        dot_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_dig) : -1;
        repeat (n_minus) text.push_back(CH_MINUS);
        for (int i = 0; i <= n_dig; i++) begin
            if (i == dot_at)
                text.push_back(CH_DOT);
            if (i < n_dig)
                text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 15) == 0)
            text.push_back(CH_DOT);
    endtask

    task put_binary();
        put_gap();
        put_number();
        put_gap();
        case ($urandom_range(0, 3))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            2: text.push_back(CH_STAR);
            default: text.push_back(CH_SLASH);
        endcase
        put_gap();
        put_number();
        put_gap();
    endtask

    // Mostly well-formed lines with random content; some broken lines and noise
    task build_line();
        int pick, idx;
        text.delete();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            put_binary();
        end else if (pick < 55) begin
            put_gap();
            put_number();
            put_gap();
        end else if (pick < 65) begin
            if ($urandom_range(0, 4) == 0)
                put_number();
            text.push_back(($urandom_range(0, 1) != 0) ? CH_UP_M : CH_LO_M);
            case ($urandom_range(0, 6))
                0: text.push_back(CH_PLUS);
                1: text.push_back(CH_MINUS);
                2: text.push_back(CH_UP_C);
                3: text.push_back(CH_LO_C);
                4: text.push_back(CH_UP_R);
                5: text.push_back(CH_LO_R);
                default: text.push_back(pick_char());
            endcase
            put_gap();
        end else if (pick < 70) begin
            if ($urandom_range(0, 3) == 0)
                put_number();
            text.push_back(CH_HASH);
            put_gap();
        end else if (pick < 85) begin
            put_binary();
            idx = $urandom_range(0, text.size());
            if ($urandom_range(0, 1) != 0) begin
                text.insert(idx, pick_char());
            end else begin
                while (text.size() > idx)
                    void'(text.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 8)) text.push_back(pick_char());
        end
    endtask

    task run_lines(int target);
        while (items_sent < target) begin
            build_line();
            send_line();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: signs and points, memory commands, odd codes
        load_text("-.5*9");
        send_line();
        load_text("5-3");
        send_line();
        load_text("1..2");
        send_line();
        load_text("Mr");
        send_line();
        load_text("M");
        send_line();
        load_text("#");
        send_line();
        text = '{8'h00};
        send_line();
        text = '{8'hFF};
        send_line();

        // Sender idles rarely, receiver often
        run_lines(230);

        // Swap the idling
        send_idle_pct = 78;
        recv_idle_pct = 15;
        run_lines(460);

        // No idling; open with a long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        run_lines(700);

        // Drain the outstanding results
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (sb.errors == 0)
            $display("tb_calculator_line_parser: done, clean");
        else
            $display("tb_calculator_line_parser: done, errors");
        $finish;
    end

endmodule
